FILE: hdl/ppps_pkg.sv
// Shared codes and pipeline control types for the palette phase pixel scanout.
package ppps_pkg;

   localparam logic [1:0] OP_PALETTE_WR = 2'd0;
   localparam logic [1:0] OP_PIXEL_WR   = 2'd1;
   localparam logic [1:0] OP_SAMPLE     = 2'd2;

   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_SCALE_X      = 1'b1;

   localparam logic [1:0] FMT_1BPP = 2'd0;
   localparam logic [1:0] FMT_2BPP = 2'd1;
   localparam logic [1:0] FMT_4BPP = 2'd2;
   localparam logic [1:0] FMT_8BPP = 2'd3;

   localparam logic [1:0] SCALE_4X = 2'd2;

   localparam logic [1:0] PIXEL_FORMAT_RESET = FMT_8BPP;
   localparam logic [1:0] SCALE_X_RESET      = 2'd0;

   // Fetch stage to palette stage.
   typedef struct packed {
      logic       valid;
      logic       out_of_span;
      logic       end_of_run;
      logic       palette_select;
      logic [2:0] slot;
      logic [1:0] phase;
   } ppps_fetch_type;

   // Palette stage to output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] sample;
      logic       out_of_span;
      logic       end_of_run;
   } ppps_result_type;

endpackage

FILE: hdl/ppps_req_if.sv
// Request channel: write and sample items into the scanout block.
interface ppps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        palette_select;
   logic [7:0]  palette_index;
   logic [31:0] palette_word;
   logic [7:0]  byte_address;
   logic [7:0]  pixel_byte;
   logic [9:0]  window_x;
   logic [9:0]  span_start;
   logic [9:0]  screen_x;
   logic        last_in_run;

   modport source (
      output valid, opcode, palette_select, palette_index, palette_word,
             byte_address, pixel_byte, window_x, span_start, screen_x, last_in_run,
      input  ready
   );

   modport sink (
      input  valid, opcode, palette_select, palette_index, palette_word,
             byte_address, pixel_byte, window_x, span_start, screen_x, last_in_run,
      output ready
   );
endinterface

FILE: hdl/ppps_rsp_if.sv
// Response channel: composite samples out of the scanout block.
interface ppps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       out_of_span;
   logic       end_of_run;

   modport source (
      output valid, sample, out_of_span, end_of_run,
      input  ready
   );

   modport sink (
      input  valid, sample, out_of_span, end_of_run,
      output ready
   );
endinterface

FILE: hdl/ppps_fetch.sv
// Column mapping, span check and pixel byte store with registered read.
module ppps_fetch
   import ppps_pkg::*;
#(
   parameter int SPAN_BYTES  = 256,
   parameter int COLUMN_BITS = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           accept,
   input  logic [1:0]     opcode,
   input  logic           palette_select,
   input  logic [7:0]     byte_address,
   input  logic [7:0]     pixel_byte,
   input  logic [9:0]     window_x,
   input  logic [9:0]     span_start,
   input  logic [9:0]     screen_x,
   input  logic           last_in_run,
   input  logic [1:0]     pixel_format,
   input  logic [1:0]     scale_x_code,
   output ppps_fetch_type fetch,
   output logic [7:0]     pixel_q
);

   localparam int SAW = $clog2(SPAN_BYTES);
   localparam logic [15:0] COL_MASK  = 16'((32'd1 << COLUMN_BITS) - 32'd1);
   localparam logic [15:0] SPAN_SIZE = 16'(SPAN_BYTES);

   logic [7:0]     store [SPAN_BYTES];
   logic [7:0]     pixel_q_ff;
   ppps_fetch_type fetch_ff, fetch_in;

   logic [15:0]    wx, start, col, rel, byte_index, wr_wide;
   logic [1:0]     shift_amt;
   logic [2:0]     slot_mask;
   logic           in_span, wr_en;
   logic [SAW-1:0] rd_addr, wr_addr;

   always_comb begin
      wx        = {6'd0, window_x} & COL_MASK;
      start     = {6'd0, span_start} & COL_MASK;
      // unused scale code behaves as the largest scale
      shift_amt = (scale_x_code > SCALE_4X) ? SCALE_4X : scale_x_code;
      col        = wx >> shift_amt;
      rel        = col - start;
      byte_index = rel >> (2'd3 - pixel_format);
      in_span    = (col >= start) && (byte_index < SPAN_SIZE);
      case (pixel_format)
         FMT_1BPP: slot_mask = 3'b111;
         FMT_2BPP: slot_mask = 3'b011;
         FMT_4BPP: slot_mask = 3'b001;
         default:  slot_mask = 3'b000;
      endcase
      rd_addr = byte_index[SAW-1:0];
      wr_wide = {8'd0, byte_address};
      wr_addr = wr_wide[SAW-1:0];
      wr_en   = accept && (opcode == OP_PIXEL_WR) && (wr_wide < SPAN_SIZE);

      fetch_in.valid          = accept && (opcode == OP_SAMPLE);
      fetch_in.out_of_span    = !in_span;
      fetch_in.end_of_run     = last_in_run;
      fetch_in.palette_select = palette_select;
      fetch_in.slot           = rel[2:0] & slot_mask;
      fetch_in.phase          = screen_x[1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= pixel_byte;
      end
      if (advance) begin
         pixel_q_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff <= '0;
      end else if (advance) begin
         fetch_ff <= fetch_in;
      end
   end

   assign fetch   = fetch_ff;
   assign pixel_q = pixel_q_ff;

endmodule

FILE: hdl/ppps_palette.sv
// Pixel unpack, dual palette store with registered read, phase byte select.
module ppps_palette
   import ppps_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            wr_en,
   input  logic            wr_select,
   input  logic [7:0]      wr_index,
   input  logic [31:0]     wr_word,
   input  logic [1:0]      pixel_format,
   input  ppps_fetch_type  fetch,
   input  logic [7:0]      pixel_q,
   output ppps_result_type result
);

   localparam int PAW = $clog2(2 * PALETTE_ENTRIES);
   localparam logic [15:0]    PAL_SIZE = 16'(PALETTE_ENTRIES);
   localparam logic [PAW-1:0] PAL_BASE = PAW'(PALETTE_ENTRIES);

   logic [31:0]    store [2 * PALETTE_ENTRIES];
   logic [31:0]    word_q_ff;
   logic           valid_ff, out_of_span_ff, end_of_run_ff, zero_ff;
   logic [1:0]     phase_ff;

   logic [2:0]     shamt;
   logic [7:0]     shifted, pix;
   logic           pix_in_palette, wr_in_range;
   logic [PAW-1:0] rd_addr, wr_addr;
   logic [31:0]    word_shifted;

   always_comb begin
      shamt   = fetch.slot << pixel_format;
      shifted = pixel_q >> shamt;
      case (pixel_format)
         FMT_1BPP: pix = shifted & 8'h01;
         FMT_2BPP: pix = shifted & 8'h03;
         FMT_4BPP: pix = shifted & 8'h0f;
         default:  pix = shifted;
      endcase
      pix_in_palette = {8'd0, pix} < PAL_SIZE;
      rd_addr = fetch.palette_select ? (PAL_BASE + PAW'(pix)) : PAW'(pix);

      wr_in_range = {8'd0, wr_index} < PAL_SIZE;
      wr_addr     = wr_select ? (PAL_BASE + PAW'(wr_index)) : PAW'(wr_index);
   end

   // a write taken on the same edge as this read belongs to a later item
   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         store[wr_addr] <= wr_word;
      end
      if (advance) begin
         word_q_ff      <= store[rd_addr];
         out_of_span_ff <= fetch.out_of_span;
         end_of_run_ff  <= fetch.end_of_run;
         zero_ff        <= fetch.out_of_span || !pix_in_palette;
         phase_ff       <= fetch.phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= fetch.valid;
      end
   end

   always_comb begin
      word_shifted       = word_q_ff >> {phase_ff, 3'b000};
      result.valid       = valid_ff;
      result.sample      = zero_ff ? 8'd0 : word_shifted[7:0];
      result.out_of_span = out_of_span_ff;
      result.end_of_run  = end_of_run_ff;
   end

endmodule

FILE: hdl/palette_phase_pixel_scanout.sv
// Top level of the palette phase pixel scanout: config, pipeline control, output register.
//
//   channel   dir  handshake        payload
//   req_ch    in   valid / ready    opcode, palette and pixel writes, sample request
//   rsp_ch    out  valid / ready    sample, out_of_span, end_of_run
//   csr_*     in   csr_wr_en        csr_index, csr_wr_data (no read-back)
//
// One item per cycle while the pipeline is not held; a sample is offered once its request
// has passed the pixel store read on the transfer edge, the palette store read and the output register.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and rsp_ch.ready is low, and req_ch.ready follows that.
// Reset clears the valid bits and the config registers; both stores come up
// undefined and need no clearing pass.
module palette_phase_pixel_scanout
   import ppps_pkg::*;
#(
   parameter int SPAN_BYTES      = 256,
   parameter int PALETTE_ENTRIES = 256,
   parameter int COLUMN_BITS     = 10
) (
   input  logic       clock,
   input  logic       reset,
   ppps_req_if.sink   req_ch,
   ppps_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [1:0] csr_wr_data
);

   logic [1:0]      pixel_format_ff, pixel_format_in;
   logic [1:0]      scale_x_code_ff, scale_x_code_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      sample_ff;
   logic            out_of_span_ff, end_of_run_ff;

   logic            advance, accept;
   ppps_fetch_type  fetch;
   ppps_result_type result;
   logic [7:0]      pixel_q;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign accept  = req_ch.valid && advance;
   assign req_ch.ready = advance;

   always_comb begin
      pixel_format_in = pixel_format_ff;
      scale_x_code_in = scale_x_code_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_in = csr_wr_data;
            CSR_SCALE_X:      scale_x_code_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= PIXEL_FORMAT_RESET;
         scale_x_code_ff <= SCALE_X_RESET;
      end else begin
         pixel_format_ff <= pixel_format_in;
         scale_x_code_ff <= scale_x_code_in;
      end
   end

   ppps_fetch #(
      .SPAN_BYTES  (SPAN_BYTES),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_fetch (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .accept         (accept),
      .opcode         (req_ch.opcode),
      .palette_select (req_ch.palette_select),
      .byte_address   (req_ch.byte_address),
      .pixel_byte     (req_ch.pixel_byte),
      .window_x       (req_ch.window_x),
      .span_start     (req_ch.span_start),
      .screen_x       (req_ch.screen_x),
      .last_in_run    (req_ch.last_in_run),
      .pixel_format   (pixel_format_ff),
      .scale_x_code   (scale_x_code_ff),
      .fetch          (fetch),
      .pixel_q        (pixel_q)
   );

   ppps_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .wr_en        (accept && (req_ch.opcode == OP_PALETTE_WR)),
      .wr_select    (req_ch.palette_select),
      .wr_index     (req_ch.palette_index),
      .wr_word      (req_ch.palette_word),
      .pixel_format (pixel_format_ff),
      .fetch        (fetch),
      .pixel_q      (pixel_q),
      .result       (result)
   );

   assign out_valid_in = advance ? result.valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_ff      <= result.sample;
         out_of_span_ff <= result.out_of_span;
         end_of_run_ff  <= result.end_of_run;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.sample      = sample_ff;
   assign rsp_ch.out_of_span = out_of_span_ff;
   assign rsp_ch.end_of_run  = end_of_run_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for palette_phase_pixel_scanout: random traffic, scoreboard, config sweep.
`timescale 1ns / 1ps

module tb;
   import ppps_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int PHASE_ITEMS     = 50;
   localparam int PRESSURE_PHASE  = 5;
   localparam int PRESSURE_CYCLES = 120;
   localparam int PIPE_CYCLES     = 4;
   localparam longint LIMIT_NS    = 20_000_000;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_style_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        palette_select;
      logic [7:0]  palette_index;
      logic [31:0] palette_word;
      logic [7:0]  byte_address;
      logic [7:0]  pixel_byte;
      logic [9:0]  window_x;
      logic [9:0]  span_start;
      logic [9:0]  screen_x;
      logic        last_in_run;
   } scan_req_type;

   typedef struct packed {
      logic [7:0] sample;
      logic       out_of_span;
      logic       end_of_run;
   } scan_sample_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [1:0] csr_wr_data;

   ppps_req_if req_ch ();
   ppps_rsp_if rsp_ch ();

   palette_phase_pixel_scanout DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block state
   logic [31:0] wave_mem [512];
   logic [7:0]  span_mem [256];
   logic [1:0]  fmt_cfg;
   logic [1:0]  scale_cfg;

   scan_req_type    scan_req_q [$];
   scan_sample_type sample_q [$];

   scan_req_type   tx_item;
   bit             tx_holding;
   int unsigned    tx_wait;
   int unsigned    rx_stall;
   logic           rx_hold;
   bit             pressure_go;
   idle_style_type send_style;
   idle_style_type recv_style;

   int unsigned n_mismatch;
   int unsigned n_checked;
   int unsigned n_outside;
   int unsigned n_run_end;
   int unsigned n_in_stall;
   int unsigned n_sent;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.opcode         = OP_SAMPLE;
      req_ch.palette_select = 1'b0;
      req_ch.palette_index  = '0;
      req_ch.palette_word   = '0;
      req_ch.byte_address   = '0;
      req_ch.pixel_byte     = '0;
      req_ch.window_x       = '0;
      req_ch.span_start     = '0;
      req_ch.screen_x       = '0;
      req_ch.last_in_run    = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_PIXEL_FORMAT;
      csr_wr_data           = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Append one item to the pending request queue.
   function automatic void add_item(input scan_req_type it);
      scan_req_q.insert(scan_req_q.size(), it);
   endfunction

   function automatic int unsigned draw_gap(input idle_style_type style);
      case (style)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         default:   return $urandom_range(0, 19);
      endcase
   endfunction

   // Apply one accepted item to the shadow state and queue the sample it produces.
   function automatic void scanout_predict(input scan_req_type it);
      scan_sample_type exp;
      int unsigned     sh, col, rel, byte_idx, slot, bits;
      logic [7:0]      pix;
      logic [31:0]     word;
      case (it.opcode)
         OP_PALETTE_WR: wave_mem[{it.palette_select, it.palette_index}] = it.palette_word;
         OP_PIXEL_WR:   span_mem[it.byte_address] = it.pixel_byte;
         OP_SAMPLE: begin
            sh  = (scale_cfg > SCALE_4X) ? 2 : scale_cfg;
            col = it.window_x >> sh;
            exp.sample      = 8'h00;
            exp.out_of_span = 1'b1;
            exp.end_of_run  = it.last_in_run;
            if (col >= it.span_start) begin
               rel      = col - it.span_start;
               byte_idx = rel >> (3 - fmt_cfg);
               if (byte_idx < 256) begin
                  bits = 1 << fmt_cfg;
                  slot = rel & ((8 >> fmt_cfg) - 1);
                  pix  = 8'((span_mem[byte_idx] >> (slot * bits)) & ((1 << bits) - 1));
                  word = wave_mem[{it.palette_select, pix}];
                  exp.sample      = word[it.screen_x[1:0] * 8 +: 8];
                  exp.out_of_span = 1'b0;
               end
            end
            sample_q.insert(sample_q.size(), exp);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : driver
      bit fire;
      if (reset) begin
         req_ch.valid <= 1'b0;
         tx_holding = 1'b0;
         tx_wait    = 0;
      end else begin
         fire = req_ch.valid && req_ch.ready;
         if (req_ch.valid && !req_ch.ready)
            n_in_stall++;
         if (fire) begin
            scanout_predict(tx_item);
            tx_holding = 1'b0;
            n_sent++;
         end
         if (!req_ch.valid || fire) begin
            if (!tx_holding && scan_req_q.size() != 0) begin
               tx_item    = scan_req_q.pop_front();
               tx_holding = 1'b1;
               tx_wait    = draw_gap(send_style);
            end
            if (tx_holding && tx_wait == 0) begin
               req_ch.valid          <= 1'b1;
               req_ch.opcode         <= tx_item.opcode;
               req_ch.palette_select <= tx_item.palette_select;
               req_ch.palette_index  <= tx_item.palette_index;
               req_ch.palette_word   <= tx_item.palette_word;
               req_ch.byte_address   <= tx_item.byte_address;
               req_ch.pixel_byte     <= tx_item.pixel_byte;
               req_ch.window_x       <= tx_item.window_x;
               req_ch.span_start     <= tx_item.span_start;
               req_ch.screen_x       <= tx_item.screen_x;
               req_ch.last_in_run    <= tx_item.last_in_run;
            end else begin
               req_ch.valid <= 1'b0;
               if (tx_wait > 0)
                  tx_wait--;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      scan_sample_type got, exp;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.sample      = rsp_ch.sample;
            got.out_of_span = rsp_ch.out_of_span;
            got.end_of_run  = rsp_ch.end_of_run;
            if (sample_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("%0t: unexpected sample %02h oos=%0b eor=%0b",
                           $realtime, got.sample, got.out_of_span, got.end_of_run);
            end else begin
               exp = sample_q.pop_front();
               n_checked++;
               if (exp.out_of_span) n_outside++;
               if (exp.end_of_run)  n_run_end++;
               if (got.sample !== exp.sample || got.out_of_span !== exp.out_of_span ||
                   got.end_of_run !== exp.end_of_run) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("%0t: sample mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
                              $realtime, exp.sample, exp.out_of_span, exp.end_of_run,
                              got.sample, got.out_of_span, got.end_of_run);
               end
            end
            rx_stall = draw_gap(recv_style);
         end
         if (rx_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_ch.ready <= !rx_hold;
         end
      end
   end

   // Long receiver hold-off so the pipeline backs up into the request channel.
   initial begin : rx_pressure
      rx_hold = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("palette_phase_pixel_scanout verification failed");
      $finish;
   end

   function automatic scan_req_type random_item();
      scan_req_type it;
      it.opcode         = 2'($urandom_range(0, 3));
      it.palette_select = 1'($urandom);
      it.palette_index  = 8'($urandom);
      it.palette_word   = $urandom;
      it.byte_address   = 8'($urandom);
      it.pixel_byte     = 8'($urandom);
      it.window_x       = 10'($urandom);
      it.span_start     = 10'($urandom);
      it.screen_x       = 10'($urandom);
      it.last_in_run    = 1'($urandom);
      return it;
   endfunction

   function automatic scan_req_type mk_sample(input logic sel, input logic [9:0] wx,
                                              input logic [9:0] start, input logic [9:0] sx,
                                              input logic last);
      scan_req_type it;
      it                = random_item();
      it.opcode         = OP_SAMPLE;
      it.palette_select = sel;
      it.window_x       = wx;
      it.span_start     = start;
      it.screen_x       = sx;
      it.last_in_run    = last;
      return it;
   endfunction

   function automatic scan_req_type mk_wave_wr(input logic sel, input logic [7:0] idx,
                                               input logic [31:0] word);
      scan_req_type it;
      it                = random_item();
      it.opcode         = OP_PALETTE_WR;
      it.palette_select = sel;
      it.palette_index  = idx;
      it.palette_word   = word;
      return it;
   endfunction

   function automatic scan_req_type mk_span_wr(input logic [7:0] addr, input logic [7:0] val);
      scan_req_type it;
      it              = random_item();
      it.opcode       = OP_PIXEL_WR;
      it.byte_address = addr;
      it.pixel_byte   = val;
      return it;
   endfunction

   // Sample aimed at the span under the current settings: mostly inside, some on either side.
   function automatic scan_req_type gen_sample();
      scan_req_type it;
      int unsigned  sh, col, span_cols, top;
      it        = random_item();
      it.opcode = OP_SAMPLE;
      sh        = (scale_cfg > SCALE_4X) ? 2 : scale_cfg;
      col       = $urandom_range(0, 1023 >> sh);
      it.window_x = 10'((col << sh) | $urandom_range(0, (1 << sh) - 1));
      span_cols = 256 << (3 - fmt_cfg);
      case ($urandom_range(0, 9))
         0, 1: ;
         2: if (col < 1023) it.span_start = 10'($urandom_range(col + 1, 1023));
         3: if (col >= span_cols) it.span_start = 10'($urandom_range(0, col - span_cols));
         default: begin
            top = (col < span_cols - 1) ? col : span_cols - 1;
            it.span_start = 10'(col - $urandom_range(0, top));
         end
      endcase
      return it;
   endfunction

   task automatic write_csr(input logic idx, input logic [1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      if (idx == CSR_PIXEL_FORMAT)
         fmt_cfg = val;
      else
         scale_cfg = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Block is idle once nothing is queued, offered or outstanding, plus pipeline flush.
   task automatic drain();
      do @(negedge clock);
      while (scan_req_q.size() != 0 || tx_holding || sample_q.size() != 0);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   initial begin : sequencer
      scan_req_type it;
      int           i, k, n, len, pick, ph;
      fmt_cfg     = PIXEL_FORMAT_RESET;
      scale_cfg   = SCALE_X_RESET;
      send_style  = IDLE_FULL;
      recv_style  = IDLE_SOME;
      pressure_go = 1'b0;
      n_mismatch  = 0;
      n_checked   = 0;
      n_outside   = 0;
      n_run_end   = 0;
      n_in_stall  = 0;
      n_sent      = 0;
      @(negedge clock iff !reset);

      // both stores filled once so no sample ever reads an unwritten entry
      for (i = 0; i < 512; i++)
         add_item(mk_wave_wr(i[8], i[7:0], $urandom));
      for (i = 0; i < 256; i++)
         add_item(mk_span_wr(i[7:0], 8'($urandom)));
      drain();

      @(negedge clock);
      add_item(mk_wave_wr(1'b0, 8'd0, 32'hffff_ffff));
      add_item(mk_wave_wr(1'b1, 8'd255, 32'h0000_0000));
      add_item(mk_wave_wr(1'b1, 8'd0, 32'h8040_2010));
      add_item(mk_wave_wr(1'b0, 8'd255, 32'h7ffe_01a5));
      add_item(mk_span_wr(8'd0, 8'h00));
      add_item(mk_span_wr(8'd255, 8'hff));
      for (i = 0; i < 4; i++)
         add_item(mk_sample(1'b1, 10'd0, 10'd0, 10'(i), 1'b0));
      add_item(mk_sample(1'b0, 10'd0, 10'd0, 10'd1020, 1'b1));
      add_item(mk_sample(1'b0, 10'd255, 10'd0, 10'd1023, 1'b0));
      add_item(mk_sample(1'b1, 10'd255, 10'd0, 10'd2, 1'b0));
      add_item(mk_sample(1'b0, 10'd1023, 10'd1023, 10'd3, 1'b0));
      // right of span
      add_item(mk_sample(1'b0, 10'd256, 10'd0, 10'd1, 1'b0));
      add_item(mk_sample(1'b1, 10'd1023, 10'd0, 10'd2, 1'b1));
      // left of span
      add_item(mk_sample(1'b0, 10'd0, 10'd1, 10'd0, 1'b1));
      add_item(mk_sample(1'b1, 10'd5, 10'd1023, 10'd3, 1'b0));
      it = random_item();
      it.opcode = OP_UNUSED;
      add_item(it);
      // read right behind a write to the same byte
      add_item(mk_span_wr(8'd7, 8'h5a));
      add_item(mk_sample(1'b0, 10'd7, 10'd0, 10'd0, 1'b1));
      add_item(mk_wave_wr(1'b0, 8'h5a, 32'hdead_beef));
      add_item(mk_sample(1'b0, 10'd7, 10'd0, 10'd3, 1'b0));
      drain();

      // every format against every scale code, unused scale code included
      for (ph = 0; ph < 16; ph++) begin
         write_csr(CSR_PIXEL_FORMAT, 2'(ph / 4));
         write_csr(CSR_SCALE_X, 2'(ph % 4));
         send_style = idle_style_type'($urandom_range(0, 2));
         recv_style = idle_style_type'($urandom_range(0, 2));
         if (ph == PRESSURE_PHASE) begin
            send_style  = IDLE_NONE;
            pressure_go = 1'b1;
         end
         @(negedge clock);
         n = 0;
         while (n < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               it = random_item();
               it.opcode = OP_PALETTE_WR;
               add_item(it);
               n++;
            end else if (pick < 26) begin
               it = random_item();
               it.opcode = OP_PIXEL_WR;
               add_item(it);
               n++;
            end else if (pick < 31) begin
               it = random_item();
               it.opcode = OP_UNUSED;
               add_item(it);
            end else if (pick < 41) begin
               // a row run: consecutive columns, last one flagged
               len = $urandom_range(4, 16);
               it  = gen_sample();
               for (k = 0; k < len; k++) begin
                  it.last_in_run = (k == len - 1);
                  add_item(it);
                  it.window_x = it.window_x + 10'd1;
                  it.screen_x = it.screen_x + 10'd1;
               end
               n += len;
            end else begin
               add_item(gen_sample());
               n++;
            end
         end
         drain();
      end

      repeat (2 * PIPE_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d samples checked (%0d out of span, %0d run ends)",
               n_sent, n_checked, n_outside, n_run_end);
      $display("all 4 pixel formats x 4 scale codes; %0d request stall cycles; %0d mismatches",
               n_in_stall, n_mismatch);
      if (n_mismatch == 0)
         $display("palette_phase_pixel_scanout verification clean");
      else
         $display("palette_phase_pixel_scanout verification failed");
      $finish;
   end

endmodule
